@@ src/gpss_pkg.sv @@
// Shared types and constants of the grid position sparse set.
package gpss_pkg;

   localparam int COORD_W  = 6;
   localparam int CMD_W    = 3;
   localparam int SLOT_W   = 12;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 13;
   localparam int COUNT_W  = 13;
   localparam int LIST_W   = 2 * COORD_W;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STS_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] STS_RANGE   = 2'd2;
   localparam logic [STATUS_W-1:0] STS_ABSENT  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_INS_RD,
      ST_INS_CHK,
      ST_REM_RD,
      ST_REM_GONE,
      ST_REM_MOVE,
      ST_RD_RD,
      ST_RD_OUT,
      ST_LKP_RD,
      ST_LKP_OUT
   } state_type;

endpackage

@@ src/gpss_ram.sv @@
// Single-port RAM with registered read data.
module gpss_ram #(
   parameter int DATA_W = 12,
   parameter int ADDR_W = 12,
   parameter int DEPTH  = 4096
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] addr,
   input  logic              wr_en,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/grid_position_sparse_set_core.sv @@
// Top level of the grid position sparse set: sequencer, shared cell unit, two RAMs.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ---------------------------
//   request  req_command, req_coord_x/_y,            taken when start && !busy
//            req_slot_index
//   result   rsp_status, rsp_out_x/_y,               one cycle, marked by
//            rsp_found_slot, rsp_entry_count          rsp_strobe
//
// Insert, read and lookup pass a RAM read state and an output state; remove
// passes ST_REM_RD, ST_REM_GONE and ST_REM_MOVE (two list reads through the
// single list port). The result is registered after the last state. Failed
// range or grid checks and unknown commands answer straight from idle. Clear
// sweeps the slot map, one cell a cycle. After reset the same sweep runs (busy
// high) and gives no result. The receiver cannot stall: each result is shown once.
module grid_position_sparse_set_core #(
   parameter int GRID_SIDE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gpss_pkg::CMD_W-1:0]    req_command,
   input  logic [gpss_pkg::COORD_W-1:0]  req_coord_x,
   input  logic [gpss_pkg::COORD_W-1:0]  req_coord_y,
   input  logic [gpss_pkg::SLOT_W-1:0]   req_slot_index,
   output logic                          rsp_strobe,
   output logic [gpss_pkg::STATUS_W-1:0] rsp_status,
   output logic [gpss_pkg::COORD_W-1:0]  rsp_out_x,
   output logic [gpss_pkg::COORD_W-1:0]  rsp_out_y,
   output logic signed [gpss_pkg::FOUND_W-1:0] rsp_found_slot,
   output logic [gpss_pkg::COUNT_W-1:0]  rsp_entry_count
);

   import gpss_pkg::*;

   localparam int CellCount = GRID_SIDE * GRID_SIDE;
   localparam int CellW     = $clog2(CellCount);
   localparam int CntW      = $clog2(CellCount + 1);

   // Shared cell unit: column and row to map cell, one constant multiply-add.
   function automatic logic [CellW-1:0] cell_of(input logic [COORD_W-1:0] cx,
                                                input logic [COORD_W-1:0] cy);
      cell_of = CellW'(int'(cy) * GRID_SIDE + int'(cx));
   endfunction

   state_type state_ff, state_in;

   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CellW-1:0]   sweep_ff, sweep_in;
   logic               clr_rsp_ff, clr_rsp_in;

   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [COORD_W-1:0]         rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0]         rsp_y_ff, rsp_y_in;
   logic signed [FOUND_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;

   // List RAM holds {row, column} of each entry; map RAM holds slot plus one.
   logic [CellW-1:0]  list_addr;
   logic              list_we;
   logic [LIST_W-1:0] list_wdata;
   logic [LIST_W-1:0] list_rdata;
   logic [CellW-1:0]  map_addr;
   logic              map_we;
   logic [CntW-1:0]   map_wdata;
   logic [CntW-1:0]   map_rdata;

   logic [COORD_W-1:0] unit_x;
   logic [COORD_W-1:0] unit_y;
   logic [CellW-1:0]   unit_cell;

   logic            accept;
   logic            req_on_grid;
   logic            req_in_range;
   logic            sweep_last;
   logic [CntW-1:0] last_slot;

   gpss_ram #(
      .DATA_W (LIST_W),
      .ADDR_W (CellW),
      .DEPTH  (CellCount)
   ) u_list_ram (
      .clock   (clock),
      .addr    (list_addr),
      .wr_en   (list_we),
      .wr_data (list_wdata),
      .rd_data (list_rdata)
   );

   gpss_ram #(
      .DATA_W (CntW),
      .ADDR_W (CellW),
      .DEPTH  (CellCount)
   ) u_map_ram (
      .clock   (clock),
      .addr    (map_addr),
      .wr_en   (map_we),
      .wr_data (map_wdata),
      .rd_data (map_rdata)
   );

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign req_on_grid  = (int'(req_coord_x) < GRID_SIDE) && (int'(req_coord_y) < GRID_SIDE);
   assign req_in_range = int'(req_slot_index) < int'(count_ff);
   assign sweep_last   = (sweep_ff == CellW'(CellCount - 1));
   assign last_slot    = count_ff - CntW'(1);

   // Feed the cell unit from the list entry during remove, else from the held item.
   always_comb begin
      if ((state_ff == ST_REM_GONE) || (state_ff == ST_REM_MOVE)) begin
         unit_x = list_rdata[COORD_W-1:0];
         unit_y = list_rdata[LIST_W-1:COORD_W];
      end else begin
         unit_x = x_ff;
         unit_y = y_ff;
      end
   end

   assign unit_cell = cell_of(unit_x, unit_y);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_CLEAR:  state_in = ST_CLEAR;
                  CMD_INSERT: state_in = req_on_grid  ? ST_INS_RD : ST_IDLE;
                  CMD_REMOVE: state_in = req_in_range ? ST_REM_RD : ST_IDLE;
                  CMD_READ:   state_in = req_in_range ? ST_RD_RD  : ST_IDLE;
                  CMD_LOOKUP: state_in = req_on_grid  ? ST_LKP_RD : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR:    state_in = sweep_last ? ST_IDLE : ST_CLEAR;
         ST_INS_RD:   state_in = ST_INS_CHK;
         ST_INS_CHK:  state_in = ST_IDLE;
         ST_REM_RD:   state_in = ST_REM_GONE;
         ST_REM_GONE: state_in = ST_REM_MOVE;
         ST_REM_MOVE: state_in = ST_IDLE;
         ST_RD_RD:    state_in = ST_RD_OUT;
         ST_RD_OUT:   state_in = ST_IDLE;
         ST_LKP_RD:   state_in = ST_LKP_OUT;
         ST_LKP_OUT:  state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath, RAM controls and result.
   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      slot_in    = slot_ff;
      count_in   = count_ff;
      sweep_in   = sweep_ff;
      clr_rsp_in = clr_rsp_ff;

      list_addr  = CellW'(slot_ff);
      list_we    = 1'b0;
      list_wdata = {y_ff, x_ff};
      map_addr   = unit_cell;
      map_we     = 1'b0;
      map_wdata  = '0;

      rsp_strobe_in = 1'b0;
      rsp_status_in = STS_OK;
      rsp_x_in      = '0;
      rsp_y_in      = '0;
      rsp_found_in  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Hold the item for the later steps.
               x_in    = req_coord_x;
               y_in    = req_coord_y;
               slot_in = req_slot_index;
               case (req_command)
                  CMD_CLEAR: begin
                     count_in   = '0;
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                  end
                  CMD_INSERT: begin
                     if (!req_on_grid) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_RANGE;
                     end
                  end
                  CMD_REMOVE, CMD_READ: begin
                     if (!req_in_range) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_RANGE;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (!req_on_grid) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_ABSENT;
                        rsp_found_in  = '1;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            // Zero one map cell a cycle; report only for a clear command.
            map_addr  = sweep_ff;
            map_we    = 1'b1;
            map_wdata = '0;
            sweep_in  = sweep_ff + CellW'(1);
            if (sweep_last) begin
               sweep_in      = '0;
               clr_rsp_in    = 1'b0;
               rsp_strobe_in = clr_rsp_ff;
            end
         end
         ST_INS_CHK: begin
            rsp_strobe_in = 1'b1;
            if (map_rdata != '0) begin
               rsp_status_in = STS_PRESENT;
            end else if (int'(count_ff) < CellCount) begin
               list_addr  = count_ff[CellW-1:0];
               list_we    = 1'b1;
               map_we     = 1'b1;
               map_wdata  = count_ff + CntW'(1);
               count_in   = count_ff + CntW'(1);
            end
         end
         ST_REM_GONE: begin
            // Drop the removed position from the map; fetch the last entry.
            map_we    = 1'b1;
            map_wdata = '0;
            list_addr = last_slot[CellW-1:0];
         end
         ST_REM_MOVE: begin
            // Move the last entry into the freed slot unless it was the last.
            if (int'(slot_ff) < int'(last_slot)) begin
               list_addr  = CellW'(slot_ff);
               list_we    = 1'b1;
               list_wdata = list_rdata;
               map_we     = 1'b1;
               map_wdata  = CntW'(slot_ff) + CntW'(1);
            end
            count_in      = last_slot;
            rsp_strobe_in = 1'b1;
         end
         ST_RD_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_x_in      = list_rdata[COORD_W-1:0];
            rsp_y_in      = list_rdata[LIST_W-1:COORD_W];
         end
         ST_LKP_OUT: begin
            rsp_strobe_in = 1'b1;
            if (map_rdata == '0) begin
               rsp_status_in = STS_ABSENT;
               rsp_found_in  = '1;
            end else begin
               rsp_found_in = FOUND_W'(map_rdata - CntW'(1));
            end
         end
         default: begin
         end
      endcase

      rsp_count_in = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         count_ff      <= '0;
         sweep_ff      <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sweep_ff      <= sweep_in;
         clr_rsp_ff    <= clr_rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_found_slot  = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
